/* hw/rtl/assert_macros.svh */
// Assertion macros used by the core RTL file of the event filter queue.
// Depends on nothing; the user supplies clock and reset names clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// The property must hold at every rising edge outside reset.
`define EFQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// The expression must never be true outside reset.
`define EFQ_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define EFQ_ASSERT(lbl, prop, msg)
`define EFQ_NEVER(lbl, expr, msg)
`endif

`endif

/* hw/rtl/efq_pkg.sv */
// Types and constants of the event filter queue.
// Used by the front end, queue, back end and core modules; depends on nothing.
`default_nettype none

package efq_pkg;

    localparam int ID_W   = 32;
    localparam int WORD_W = 64;
    localparam int LONG_W = 64;
    localparam int OVF_W  = 32;
    localparam int ENTRY_W = ID_W + WORD_W + LONG_W;

    localparam logic [OVF_W-1:0] OVF_MAX = '1;

    typedef enum logic [2:0] {
        REQ_EVENT = 3'd0,
        REQ_SUB   = 3'd1,
        REQ_UNSUB = 3'd2,
        REQ_POP   = 3'd3,
        REQ_OVF   = 3'd4
    } req_t;

    // Work left for the back end once the front end has classified a request.
    typedef enum logic [1:0] {
        BK_DIRECT = 2'd0,
        BK_PUSH   = 2'd1,
        BK_POP    = 2'd2,
        BK_OVF    = 2'd3
    } back_op_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_READ = 1'b1
    } back_state_t;

    typedef struct packed {
        back_op_t          op;
        logic [ID_W-1:0]   id;
        logic [WORD_W-1:0] word;
        logic [LONG_W-1:0] lng;
        logic              matched;
        logic              forward;
        logic              status;
    } efq_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/efq_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module efq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/efq_queue.sv */
// Two-entry command queue between the front end and the back end.
// Depends on efq_pkg.
`default_nettype none

module efq_queue
    import efq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire efq_cmd_t push_cmd,
    output logic          full,
    input  wire logic     pop,
    output logic          head_valid,
    output efq_cmd_t      head
);

    efq_cmd_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/efq_front.sv */
// Front end: accepts requests, keeps the subscription table and classifies events.
// Depends on efq_pkg; hands one command per request to the queue.
`default_nettype none

module efq_front
    import efq_pkg::*;
#(
    parameter int SUB_ENTRIES = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [2:0]        req_type,
    input  wire logic [ID_W-1:0]   msg_id,
    input  wire logic [WORD_W-1:0] word_param,
    input  wire logic [LONG_W-1:0] long_param,
    input  wire logic              consume_flag,
    output efq_cmd_t               cmd
);

    localparam int CNT_W = $clog2(SUB_ENTRIES + 1);
    localparam int IDX_W = (SUB_ENTRIES > 1) ? $clog2(SUB_ENTRIES) : 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SUB_ENTRIES);

    logic [ID_W-1:0]  sub_ids_reg [SUB_ENTRIES];
    logic [ID_W-1:0]  sub_ids_next [SUB_ENTRIES];
    logic             sub_cons_reg [SUB_ENTRIES];
    logic             sub_cons_next [SUB_ENTRIES];
    logic [CNT_W-1:0] sub_count_reg, sub_count_next;

    logic [SUB_ENTRIES-1:0] hit;
    logic [IDX_W-1:0]       hit_idx;
    logic                   any_hit;
    logic                   hit_cons;
    logic                   table_full;

    // Ids in the table are unique, so at most one hit bit is set and an
    // OR of the hit indexes gives the matching entry.
    always_comb
    begin
        hit_idx  = '0;
        hit_cons = 1'b0;
        for (int i = 0; i < SUB_ENTRIES; i++)
        begin
            hit[i] = (CNT_W'(i) < sub_count_reg) && (sub_ids_reg[i] == msg_id);
            if (hit[i])
            begin
                hit_idx  = hit_idx | IDX_W'(i);
                hit_cons = hit_cons | sub_cons_reg[i];
            end
        end
        any_hit    = |hit;
        table_full = (sub_count_reg == CNT_FULL);
    end

    always_comb
    begin
        cmd.op      = BK_DIRECT;
        cmd.id      = msg_id;
        cmd.word    = word_param;
        cmd.lng     = long_param;
        cmd.matched = 1'b0;
        cmd.forward = 1'b0;
        cmd.status  = 1'b0;
        unique case (req_type)
            REQ_EVENT:
            begin
                if (any_hit)
                begin
                    cmd.op      = BK_PUSH;
                    cmd.matched = 1'b1;
                    cmd.forward = ~hit_cons;
                end
                else
                begin
                    cmd.forward = 1'b1;
                end
            end
            REQ_SUB:
            begin
                cmd.status = ~any_hit & table_full;
            end
            REQ_POP:
            begin
                cmd.op = BK_POP;
            end
            REQ_OVF:
            begin
                cmd.op = BK_OVF;
            end
            default:
            begin
                cmd.op = BK_DIRECT;
            end
        endcase
    end

    always_comb
    begin
        sub_count_next = sub_count_reg;
        for (int i = 0; i < SUB_ENTRIES; i++)
        begin
            sub_ids_next[i]  = sub_ids_reg[i];
            sub_cons_next[i] = sub_cons_reg[i];
        end
        if (accept && (req_type == REQ_SUB))
        begin
            if (any_hit)
            begin
                for (int i = 0; i < SUB_ENTRIES; i++)
                begin
                    if (hit[i])
                    begin
                        sub_cons_next[i] = consume_flag;
                    end
                end
            end
            else if (!table_full)
            begin
                for (int i = 0; i < SUB_ENTRIES; i++)
                begin
                    if (CNT_W'(i) == sub_count_reg)
                    begin
                        sub_ids_next[i]  = msg_id;
                        sub_cons_next[i] = consume_flag;
                    end
                end
                sub_count_next = sub_count_reg + CNT_W'(1);
            end
        end
        else if (accept && (req_type == REQ_UNSUB) && any_hit)
        begin
            // Every entry from the removed one upward takes its upper neighbor.
            for (int i = 0; i + 1 < SUB_ENTRIES; i++)
            begin
                if (IDX_W'(i) >= hit_idx)
                begin
                    sub_ids_next[i]  = sub_ids_reg[i+1];
                    sub_cons_next[i] = sub_cons_reg[i+1];
                end
            end
            sub_count_next = sub_count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_count_reg <= '0;
        end
        else
        begin
            sub_count_reg <= sub_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SUB_ENTRIES; i++)
        begin
            sub_ids_reg[i]  <= sub_ids_next[i];
            sub_cons_reg[i] <= sub_cons_next[i];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/efq_back.sv */
// Back end: event ring with drop-oldest overflow, overflow counter and result register.
// Depends on efq_pkg and efq_ram.
`default_nettype none

module efq_back
    import efq_pkg::*;
#(
    parameter int RING_SLOTS = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire efq_cmd_t          q_head,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   matched,
    output logic                   forward,
    output logic                   status,
    output logic                   entry_valid,
    output logic [ID_W-1:0]        entry_msg,
    output logic [WORD_W-1:0]      entry_word,
    output logic signed [LONG_W-1:0] entry_long,
    output logic [OVF_W-1:0]       dropped_count
);

    localparam int PTR_W = $clog2(RING_SLOTS);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_SLOTS - 1);

    back_state_t       state_reg, state_next;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [OVF_W-1:0]  ovf_reg, ovf_next;

    logic              out_valid_reg, out_valid_next;
    logic              matched_reg, matched_next;
    logic              forward_reg, forward_next;
    logic              status_reg, status_next;
    logic              ev_reg, ev_next;
    logic [ID_W-1:0]   emsg_reg, emsg_next;
    logic [WORD_W-1:0] eword_reg, eword_next;
    logic [LONG_W-1:0] elong_reg, elong_next;
    logic [OVF_W-1:0]  drop_reg, drop_next;

    logic               ram_we;
    logic               ram_re;
    logic [ENTRY_W-1:0] ram_rdata;

    logic              out_free;
    logic              go;
    logic              ring_empty;
    logic [PTR_W-1:0]  wr_inc;
    logic [PTR_W-1:0]  rd_inc;

    assign out_free   = ~out_valid_reg | ~out_stall;
    assign go         = (state_reg == BK_IDLE) && q_valid && out_free;
    assign q_pop      = go;
    assign ring_empty = (wr_ptr_reg == rd_ptr_reg);
    assign wr_inc     = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_inc     = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);

    efq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_SLOTS)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata ({q_head.id, q_head.word, q_head.lng}),
        .re    (ram_re),
        .raddr (rd_ptr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (go && (q_head.op == BK_POP) && !ring_empty)
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg & out_stall;
        matched_next   = matched_reg;
        forward_next   = forward_reg;
        status_next    = status_reg;
        ev_next        = ev_reg;
        emsg_next      = emsg_reg;
        eword_next     = eword_reg;
        elong_next     = elong_reg;
        drop_next      = drop_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (go)
                begin
                    out_valid_next = 1'b1;
                    matched_next   = q_head.matched;
                    forward_next   = q_head.forward;
                    status_next    = q_head.status;
                    ev_next        = 1'b0;
                    emsg_next      = '0;
                    eword_next     = '0;
                    elong_next     = '0;
                    drop_next      = '0;
                    unique case (q_head.op)
                        BK_PUSH:
                        begin
                            ram_we      = 1'b1;
                            wr_ptr_next = wr_inc;
                            // A full ring loses its oldest event.
                            if (wr_inc == rd_ptr_reg)
                            begin
                                rd_ptr_next = rd_inc;
                                if (ovf_reg != OVF_MAX)
                                begin
                                    ovf_next = ovf_reg + OVF_W'(1);
                                end
                            end
                        end
                        BK_POP:
                        begin
                            if (!ring_empty)
                            begin
                                // The result waits for the registered read.
                                out_valid_next = 1'b0;
                                ram_re         = 1'b1;
                                rd_ptr_next    = rd_inc;
                            end
                        end
                        BK_OVF:
                        begin
                            drop_next = ovf_reg;
                            ovf_next  = '0;
                        end
                        BK_DIRECT:
                        begin
                            ovf_next = ovf_reg;
                        end
                        default:
                        begin
                            ovf_next = ovf_reg;
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                out_valid_next = 1'b1;
                matched_next   = 1'b0;
                forward_next   = 1'b0;
                status_next    = 1'b0;
                ev_next        = 1'b1;
                emsg_next      = ram_rdata[ENTRY_W-1 -: ID_W];
                eword_next     = ram_rdata[LONG_W +: WORD_W];
                elong_next     = ram_rdata[LONG_W-1:0];
                drop_next      = '0;
            end
            default:
            begin
                out_valid_next = out_valid_reg & out_stall;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            ovf_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
        forward_reg <= forward_next;
        status_reg  <= status_next;
        ev_reg      <= ev_next;
        emsg_reg    <= emsg_next;
        eword_reg   <= eword_next;
        elong_reg   <= elong_next;
        drop_reg    <= drop_next;
    end

    assign out_valid     = out_valid_reg;
    assign matched       = matched_reg;
    assign forward       = forward_reg;
    assign status        = status_reg;
    assign entry_valid   = ev_reg;
    assign entry_msg     = emsg_reg;
    assign entry_word    = eword_reg;
    assign entry_long    = $signed(elong_reg);
    assign dropped_count = drop_reg;

endmodule

`default_nettype wire

/* hw/rtl/event_filter_drop_oldest_queue_core.sv */
// Subscription-filtered event queue with drop-oldest overflow.
//
// Requests enter on the in channel (in_valid, in_stall) and each gives exactly
// one result on the out channel (out_valid, out_stall), in request order.
// A request is either an event, a subscribe, an unsubscribe, a pop of the
// oldest queued event or a read-and-clear of the overflow counter.
//
// The front end takes one transfer per cycle while in_stall is low; it matches
// the event id against all entries at once and updates the table in that cycle.
// A two-entry queue carries the classified request to the back end, which
// finishes most requests in BK_IDLE; a pop of a non-empty ring goes on to
// BK_READ, because the ring memory has a registered read port, and takes no
// new request there. The result is registered in the result register.
//
// Reset clears the subscription count, the queue, the ring pointers, the
// overflow counter and out_valid, but not entry_valid; no clearing pass is run.
// While out_valid and out_stall are both high the result register holds, the
// back end stops, and once the queue fills the front end raises in_stall.
// Depends on efq_pkg, efq_front, efq_queue, efq_back, efq_ram, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module event_filter_drop_oldest_queue_core
    import efq_pkg::*;
#(
    parameter int RING_SLOTS  = 64,
    parameter int SUB_ENTRIES = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [2:0]          req_type,
    input  wire logic [ID_W-1:0]     msg_id,
    input  wire logic [WORD_W-1:0]   word_param,
    input  wire logic signed [LONG_W-1:0] long_param,
    input  wire logic                consume_flag,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     matched,
    output logic                     forward,
    output logic                     status,
    output logic                     entry_valid,
    output logic [ID_W-1:0]          entry_msg,
    output logic [WORD_W-1:0]        entry_word,
    output logic signed [LONG_W-1:0] entry_long,
    output logic [OVF_W-1:0]         dropped_count
);

    logic     in_accept;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;
    efq_cmd_t front_cmd;
    efq_cmd_t q_head;

    assign in_stall  = q_full;
    assign in_accept = in_valid & ~in_stall;

    efq_front #(
        .SUB_ENTRIES (SUB_ENTRIES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .req_type     (req_type),
        .msg_id       (msg_id),
        .word_param   (word_param),
        .long_param   ($unsigned(long_param)),
        .consume_flag (consume_flag),
        .cmd          (front_cmd)
    );

    efq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_accept),
        .push_cmd   (front_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head       (q_head)
    );

    efq_back #(
        .RING_SLOTS (RING_SLOTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .matched       (matched),
        .forward       (forward),
        .status        (status),
        .entry_valid   (entry_valid),
        .entry_msg     (entry_msg),
        .entry_word    (entry_word),
        .entry_long    (entry_long),
        .dropped_count (dropped_count)
    );

    // The queue must never be written while full or read while empty.
    `EFQ_NEVER(a_push_full, in_accept && q_full, "queue written while full")
    `EFQ_ASSERT(a_pop_valid, q_pop |-> q_valid, "queue read while empty")
    // Every input transfer leaves a command waiting for the back end.
    `EFQ_ASSERT(a_push_visible, in_accept |=> q_valid, "accepted request lost")

endmodule

`default_nettype wire
